/* hdl/pcpb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent table of the polar min-range binner.
package pcpb_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ1,
    OP_SQ2,
    OP_ITER,
    OP_CHECK,
    OP_MUL1,
    OP_MUL2,
    OP_BIN,
    OP_MRD,
    OP_UPD,
    OP_RD_ISSUE,
    OP_RD_LOAD,
    OP_FILL_INIT,
    OP_FILL_CLR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       iter_last;
    logic       fill_last;
    logic       keep;
  } dp_sts_t;

  localparam int unsigned ANG_W        = 25;
  localparam int unsigned Z_W          = 27;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned BIN_DIV      = 45;
  localparam int unsigned BIN_SH       = 19;

  localparam logic signed [Z_W-1:0] ANG_FULL    = 27'sd23592960;
  localparam logic signed [Z_W-1:0] ANG_HALF    = 27'sd11796480;
  localparam logic signed [Z_W-1:0] ANG_QUARTER = 27'sd5898240;

  localparam logic [15:0] RESET_MIN_RANGE = 16'd100;
  localparam logic [15:0] RESET_MAX_RANGE = 16'd10000;

  localparam logic REG_MIN_RANGE = 1'b0;
  localparam logic REG_MAX_RANGE = 1'b1;

  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] a;
    case (i)
      4'd0:    a = 22'd2949120;
      4'd1:    a = 22'd1740967;
      4'd2:    a = 22'd919879;
      4'd3:    a = 22'd466945;
      4'd4:    a = 22'd234379;
      4'd5:    a = 22'd117304;
      4'd6:    a = 22'd58666;
      4'd7:    a = 22'd29335;
      4'd8:    a = 22'd14668;
      4'd9:    a = 22'd7334;
      4'd10:   a = 22'd3667;
      4'd11:   a = 22'd1833;
      4'd12:   a = 22'd917;
      4'd13:   a = 22'd458;
      4'd14:   a = 22'd229;
      default: a = 22'd115;
    endcase
    return a;
  endfunction

endpackage

/* hdl/pcpb_item_if.sv */
`timescale 1ns / 1ps
// Input channel of the binner: command and point payload with valid/ready.
interface pcpb_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               point_ok;
  logic [8:0]         bin_index;

  modport source (output valid, cmd, point_x, point_y, point_ok, bin_index, input ready);
  modport sink (input valid, cmd, point_x, point_y, point_ok, bin_index, output ready);
endinterface

/* hdl/pcpb_result_if.sv */
`timescale 1ns / 1ps
// Result channel of the binner: one bin range per read beat with valid/ready.
interface pcpb_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] bin_range_mm;

  modport source (output valid, bin_range_mm, input ready);
  modport sink (input valid, bin_range_mm, output ready);
endinterface

/* hdl/pcpb_dp.sv */
`timescale 1ns / 1ps
// Datapath: squares, iterative square root and CORDIC, bin mapping and the bin memory.
module pcpb_dp #(
  parameter int unsigned NUM_BINS = 360
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcpb_pkg::dp_cmd_t  cmd_i,
  output pcpb_pkg::dp_sts_t  sts_o,
  input  logic [1:0]         in_cmd_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic               point_ok_i,
  input  logic [8:0]         bin_index_i,
  input  logic [15:0]        min_range_i,
  input  logic [15:0]        max_range_i,
  output logic [15:0]        bin_range_mm_o
);
  import pcpb_pkg::*;

  localparam int unsigned AW    = $clog2(NUM_BINS);
  localparam int unsigned NBW   = $clog2(NUM_BINS + 1);
  localparam int unsigned PW1   = ANG_W + NBW;
  localparam int unsigned QW    = $clog2(BIN_DIV * NUM_BINS);
  localparam int unsigned KSH   = QW + 6;
  localparam int unsigned MW    = KSH - 5;
  localparam int unsigned PW2   = QW + MW;
  localparam int unsigned BQW   = PW2 - KSH;
  localparam longint      RECIP_L = ((64'd1 << KSH) + BIN_DIV - 1) / BIN_DIV;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic signed [15:0] px_q, py_q;
  logic               ok_q;
  logic [8:0]         idx_q;
  logic [31:0]        sq_q;
  logic [31:0]        rem_q, root_q;
  logic [3:0]         cnt_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [Z_W-1:0] z_q;
  logic               neg_q;
  logic [ANG_W-1:0]   ang_q;
  logic [PW1-1:0]     prod1_q;
  logic [PW2-1:0]     prod2_q;
  logic [AW-1:0]      bin_q;
  logic [AW-1:0]      fill_q;
  logic [15:0]        rdata_q;
  logic [15:0]        out_q;
  logic [15:0]        mem_q [NUM_BINS];

  logic signed [31:0] sqx_w, sqy_w;
  logic signed [16:0] ax_w, ay_w;
  logic signed [33:0] xs_w, ys_w;
  logic [Z_W-1:0]     at_w;
  logic [31:0]        bit_w, trial_w;
  logic signed [Z_W-1:0] zb_w, zw_w;
  logic [ANG_W-1:0]   ang_w;
  logic [QW-1:0]      qv_w;
  logic [BQW-1:0]     bq_w;
  logic [AW-1:0]      idx_sat_w;
  logic [15:0]        root16_w;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata;

  assign sqx_w    = px_q * px_q;
  assign sqy_w    = py_q * py_q;
  assign ax_w     = px_q[15] ? -$signed({px_q[15], px_q}) : $signed({px_q[15], px_q});
  assign ay_w     = px_q[15] ? -$signed({py_q[15], py_q}) : $signed({py_q[15], py_q});
  assign xs_w     = cx_q >>> cnt_q;
  assign ys_w     = cy_q >>> cnt_q;
  assign at_w     = {5'b0, atan_q16(cnt_q)};
  assign bit_w    = 32'h4000_0000 >> {cnt_q, 1'b0};
  assign trial_w  = root_q + bit_w;
  assign root16_w = root_q[15:0];
  assign qv_w     = QW'(prod1_q >> BIN_SH);
  assign bq_w     = prod2_q[PW2-1:KSH];
  assign idx_sat_w = (32'(idx_q) >= 32'(NUM_BINS)) ? AW'(NUM_BINS - 1) : AW'(idx_q);

  always_comb begin
    zb_w = z_q + (neg_q ? ANG_HALF : '0);
    if (zb_w < 0) begin
      zw_w = zb_w + ANG_FULL;
    end else if (zb_w >= ANG_FULL) begin
      zw_w = zb_w - ANG_FULL;
    end else begin
      zw_w = zb_w;
    end
    if (py_q == 16'sd0) begin
      ang_w = px_q[15] ? ANG_W'(ANG_HALF) : '0;
    end else if (px_q == 16'sd0) begin
      ang_w = py_q[15] ? ANG_W'(ANG_HALF + ANG_QUARTER) : ANG_W'(ANG_QUARTER);
    end else begin
      ang_w = ANG_W'(zw_w);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_q;
    mem_wdata = max_range_i;
    mem_re    = 1'b0;
    mem_raddr = bin_q;
    case (cmd_i.op)
      OP_FILL_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_MAX_RANGE;
      end
      OP_FILL_CLR: mem_we = 1'b1;
      OP_UPD: begin
        mem_we    = (root16_w < rdata_q);
        mem_waddr = bin_q;
        mem_wdata = root16_w;
      end
      OP_MRD: mem_re = 1'b1;
      OP_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = idx_sat_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.op == OP_ITER) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (cmd_i.op == OP_FILL_INIT || cmd_i.op == OP_FILL_CLR) begin
        fill_q <= (fill_q == AW'(NUM_BINS - 1)) ? '0 : fill_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        px_q  <= point_x_i;
        py_q  <= point_y_i;
        ok_q  <= point_ok_i;
        idx_q <= bin_index_i;
      end
      OP_SQ1: sq_q <= 32'(sqx_w);
      OP_SQ2: begin
        rem_q  <= sq_q + 32'(sqy_w);
        root_q <= '0;
        cx_q   <= {{3{ax_w[16]}}, ax_w, 14'b0};
        cy_q   <= {{3{ay_w[16]}}, ay_w, 14'b0};
        z_q    <= '0;
        neg_q  <= px_q[15];
      end
      OP_ITER: begin
        if (rem_q >= trial_w) begin
          rem_q  <= rem_q - trial_w;
          root_q <= (root_q >> 1) + bit_w;
        end else begin
          root_q <= root_q >> 1;
        end
        if (!cy_q[33]) begin
          cx_q <= cx_q + ys_w;
          cy_q <= cy_q - xs_w;
          z_q  <= z_q + $signed(at_w);
        end else begin
          cx_q <= cx_q - ys_w;
          cy_q <= cy_q + xs_w;
          z_q  <= z_q - $signed(at_w);
        end
      end
      OP_CHECK: ang_q <= ang_w;
      OP_MUL1: prod1_q <= ang_q * NBW'(NUM_BINS);
      OP_MUL2: prod2_q <= qv_w * RECIP;
      OP_BIN: bin_q <= (bq_w > BQW'(NUM_BINS - 1)) ? AW'(NUM_BINS - 1) : AW'(bq_w);
      OP_RD_LOAD: out_q <= rdata_q;
      default: ;
    endcase
  end

  assign sts_o.in_cmd    = in_cmd_i;
  assign sts_o.iter_last = (cnt_q == 4'(CORDIC_STEPS - 1));
  assign sts_o.fill_last = (fill_q == AW'(NUM_BINS - 1));
  assign sts_o.keep      = ok_q && (root16_w >= min_range_i) && (root16_w <= max_range_i);
  assign bin_range_mm_o  = out_q;

endmodule

/* hdl/pcpb_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences the datapath per command and owns the handshake state.
module pcpb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pcpb_pkg::dp_sts_t sts_i,
  output pcpb_pkg::dp_cmd_t cmd_o
);
  import pcpb_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SQ1,
    S_SQ2,
    S_ITER,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_BIN,
    S_MRD,
    S_UPD,
    S_RD_WAIT,
    S_RD_DATA,
    S_CLR
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_FILL_INIT;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          unique case (sts_i.in_cmd)
            CMD_ADD:   state_d = S_SQ1;
            CMD_READ:  state_d = S_RD_WAIT;
            CMD_CLEAR: state_d = S_CLR;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SQ1: begin
        cmd_o.op = OP_SQ1;
        state_d  = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.op = OP_SQ2;
        state_d  = S_ITER;
      end
      S_ITER: begin
        cmd_o.op = OP_ITER;
        if (sts_i.iter_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.op = OP_CHECK;
        state_d  = sts_i.keep ? S_MUL1 : S_IDLE;
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_BIN;
      end
      S_BIN: begin
        cmd_o.op = OP_BIN;
        state_d  = S_MRD;
      end
      S_MRD: begin
        cmd_o.op = OP_MRD;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        state_d  = S_IDLE;
      end
      S_RD_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_RD_ISSUE;
          state_d  = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        cmd_o.op = OP_RD_LOAD;
        state_d  = S_IDLE;
      end
      S_CLR: begin
        cmd_o.op = OP_FILL_CLR;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_RD_DATA) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_rise_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RD_DATA))
    else $error("Result beat raised outside a bin read.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_DATA) |-> !out_valid_q)
    else $error("Bin read would overwrite a pending result beat.");

  a_iter_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER && !sts_i.iter_last) |=> (state_q == S_ITER))
    else $error("Iteration left before the last step.");

endmodule

/* hdl/point_cloud_polar_min_binner_top.sv */
`timescale 1ns / 1ps
// Top level of the polar min-range binner: APB registers, controller and datapath.
//
// An add-point beat occupies the block from acceptance to the next ready: squaring, the
// 16 shared square-root and CORDIC iterations, bin mapping and a read-modify-write of the
// bin memory, which has separate read and write ports; a point dropped by the range or
// finite check frees the block right after that check. A read beat waits until the result
// register is free, then loads it from the bin; a clear beat writes the maximum range
// register to every bin, one memory write a cycle. After reset the block fills all NUM_BINS
// bins with 10000 mm before it first raises ready; register writes are taken at any time.
module point_cloud_polar_min_binner_top #(
  parameter int unsigned NUM_BINS = 360
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcpb_item_if.sink   item_i,
  pcpb_result_if.source result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcpb_pkg::*;

  logic [15:0] min_range_q, max_range_q;
  dp_cmd_t     dp_cmd;
  dp_sts_t     dp_sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= RESET_MIN_RANGE;
      max_range_q <= RESET_MAX_RANGE;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MIN_RANGE) begin
        min_range_q <= pwdata[15:0];
      end else begin
        max_range_q <= pwdata[15:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = {16'b0, (paddr[2] == REG_MAX_RANGE) ? max_range_q : min_range_q};

  pcpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  pcpb_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .in_cmd_i       (item_i.cmd),
    .point_x_i      (item_i.point_x),
    .point_y_i      (item_i.point_y),
    .point_ok_i     (item_i.point_ok),
    .bin_index_i    (item_i.bin_index),
    .min_range_i    (min_range_q),
    .max_range_i    (max_range_q),
    .bin_range_mm_o (result_o.bin_range_mm)
  );

endmodule
